// ===== hw/rtl/slab_bitmap_slot_allocator_assert.svh =====
// Assertion macros for the slab slot allocator. Both expect i_clk and i_rst_n
// in the scope where they are used.
`ifndef SLAB_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define SLAB_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SBSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slab allocator check failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define SBSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slab allocator check failed (next cycle)");

`else

`define SBSA_ASSERT_IMP(lbl, ante, cons)
`define SBSA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/sbsa_pkg.sv =====
package sbsa_pkg;

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int OFS_W  = 22;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 9;
    localparam int CNT_W  = 10;
    localparam int SIZE_W = 17;

    // Bitmap organization.
    localparam int WORD_BITS     = 64;
    localparam int WB_LOG        = 6;
    localparam int DEF_MAX_SLOTS = 512;

    // Slot count and object size after reset.
    localparam int RST_COUNT = 8;
    localparam int RST_SIZE  = 64;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_OBJ_COUNT = 1'b0;
    localparam logic CFG_OBJ_SIZE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;        // capture input item and configuration
        logic              init_wr;     // write one init word, advance word counter
        logic              rd_scan;     // read bitmap word at word counter
        logic              wcnt_inc;    // advance word counter
        logic              alloc_take;  // mark lowest free bit of read word used
        logic              mul;         // compute slot offset
        logic              div_start;   // start offset division
        logic              rd_free;     // read bitmap word of quotient slot
        logic              free_clr;    // clear the slot bit
        logic              finish;      // load the output register
        logic [STAT_W-1:0] status;
        logic              use_idx;
        logic              use_off;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wcnt_last;
        logic scan_more;
        logic word_full;
        logic div_done;
        logic out_range;
        logic bit_used;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/sbsa_div.sv =====
module sbsa_div
    import sbsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OFS_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic [OFS_W-1:0]  o_quotient,
    output logic              o_done
);

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of r_q while quotient bits shift in at the bottom.
    localparam int CNTW = $clog2(OFS_W + 1);

    logic [OFS_W-1:0]  r_q;
    logic [SIZE_W-1:0] r_rem;
    logic [CNTW-1:0]   r_cnt;
    logic              r_done;

    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W+1:0] diff;

    assign rem_sh = {r_rem, r_q[OFS_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNTW'(OFS_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNTW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            if (!diff[SIZE_W+1]) begin
                r_rem <= diff[SIZE_W-1:0];
                r_q   <= {r_q[OFS_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[SIZE_W-1:0];
                r_q   <= {r_q[OFS_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

// ===== hw/rtl/sbsa_ctrl.sv =====
module sbsa_ctrl
    import sbsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_stall,
    output t_dp_cmd          o_cmd,
    input  t_dp_stat         i_stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_use_idx, n_use_idx;
    logic              r_use_off, n_use_off;

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_use_idx = r_use_idx;
        n_use_off = r_use_off;
        o_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.wcnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_status   = ST_OK;
                    n_use_idx  = 1'b0;
                    n_use_off  = 1'b0;
                    unique case (i_command)
                        CMD_INIT:  n_state = S_INIT;
                        CMD_ALLOC: n_state = S_SCAN_RD;
                        CMD_FREE:  n_state = S_DIV_GO;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.wcnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_more) begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_SCAN_CHK;
                end else begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.word_full) begin
                    o_cmd.wcnt_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end else begin
                    o_cmd.alloc_take = 1'b1;
                    n_state          = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_use_idx = 1'b1;
                n_use_off = 1'b1;
                n_state   = S_DONE;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FREE_RD;
                end
            end
            S_FREE_RD: begin
                if (i_stat.out_range) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.rd_free = 1'b1;
                    n_state       = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                n_use_idx = 1'b1;
                if (i_stat.bit_used) begin
                    o_cmd.free_clr = 1'b1;
                end else begin
                    n_status = ST_DOUBLE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.status  = r_status;
        o_cmd.use_idx = r_use_idx;
        o_cmd.use_off = r_use_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_status  <= ST_OK;
            r_use_idx <= 1'b0;
            r_use_off <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_use_idx <= n_use_idx;
            r_use_off <= n_use_off;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/sbsa_dpath.sv =====
module sbsa_dpath
    import sbsa_pkg::*;
#(
    parameter int MaxSlots = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic [OFS_W-1:0]  i_free_offset,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_slot_index,
    output logic [OFS_W-1:0]  o_slot_offset,
    output logic [CNT_W-1:0]  o_free_slots
);

    localparam int Words = (MaxSlots + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
    localparam int WCW   = $clog2(Words + 1);
    localparam int CW    = $clog2(MaxSlots + 1);
    localparam int PW    = $clog2(MaxSlots);
    localparam int SW    = (WCW + WB_LOG > CW) ? WCW + WB_LOG : CW;
    localparam int MW    = PW + SIZE_W;

    function automatic logic [WB_LOG-1:0] f_low_zero(input logic [WORD_BITS-1:0] w);
        logic [WB_LOG-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = WB_LOG'(i);
            end
        end
        return pos;
    endfunction

    // Configuration registers.
    logic [CNT_W-1:0]  r_obj_count;
    logic [SIZE_W-1:0] r_obj_size;

    // Per-item working registers.
    logic [OFS_W-1:0]  r_offset;
    logic [CW-1:0]     r_n;
    logic [SIZE_W-1:0] r_size;
    logic [WCW-1:0]    r_wcnt;
    logic [PW-1:0]     r_pos;
    logic [OFS_W-1:0]  r_soff;
    logic [CW-1:0]     r_free_count;

    // Bitmap memory, one word per entry, registered read.
    logic [WORD_BITS-1:0] r_mem [Words];
    logic [WORD_BITS-1:0] r_rdata;

    // Output register.
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_index;
    logic [OFS_W-1:0]  r_slot_off;
    logic [CNT_W-1:0]  r_fslots;

    logic [CW-1:0]        eff_n;
    logic [SIZE_W-1:0]    eff_size;
    logic [SW-1:0]        first_bit;
    logic [SW-1:0]        n_ext;
    logic [SW-1:0]        n_rem;
    logic [WORD_BITS-1:0] init_word;
    logic [WB_LOG-1:0]    low_zero;
    logic [OFS_W-1:0]     quotient;
    logic                 div_done;
    logic [MW-1:0]        prod;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic                 out_free;

    assign eff_n    = (32'(r_obj_count) > MaxSlots) ? CW'(MaxSlots) : CW'(r_obj_count);
    assign eff_size = (r_obj_size == '0) ? SIZE_W'(1) : r_obj_size;

    // Init pattern for the word at r_wcnt: slots below the count free, others used.
    assign first_bit = SW'({r_wcnt, {WB_LOG{1'b0}}});
    assign n_ext     = SW'(r_n);
    assign n_rem     = n_ext - first_bit;

    always_comb begin
        if (n_ext >= first_bit + SW'(WORD_BITS)) begin
            init_word = '0;
        end else if (n_ext <= first_bit) begin
            init_word = '1;
        end else begin
            init_word = {WORD_BITS{1'b1}} << n_rem[WB_LOG-1:0];
        end
    end

    assign low_zero = f_low_zero(r_rdata);
    assign prod     = MW'(r_pos) * MW'(r_size);
    assign out_free = !r_out_valid || !i_stall;

    sbsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_offset),
        .i_divisor  (r_size),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(r_wcnt);
        mem_wdata = init_word;
        if (i_cmd.init_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.alloc_take) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata | (WORD_BITS'(1) << low_zero);
        end else if (i_cmd.free_clr) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_pos >> WB_LOG);
            mem_wdata = r_rdata & ~(WORD_BITS'(1) << r_pos[WB_LOG-1:0]);
        end
        mem_re    = i_cmd.rd_scan || i_cmd.rd_free;
        mem_raddr = i_cmd.rd_free ? AW'(quotient >> WB_LOG) : AW'(r_wcnt);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Configuration, item capture, word counter and free count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_count  <= CNT_W'(RST_COUNT);
            r_obj_size   <= SIZE_W'(RST_SIZE);
            r_n          <= CW'(RST_COUNT);
            r_wcnt       <= '0;
            r_free_count <= CW'(RST_COUNT);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OBJ_COUNT: r_obj_count <= i_cfg_data[CNT_W-1:0];
                    CFG_OBJ_SIZE:  r_obj_size  <= i_cfg_data;
                    default:       ;
                endcase
            end
            if (i_cmd.load) begin
                r_n    <= eff_n;
                r_wcnt <= '0;
            end else if (i_cmd.init_wr || i_cmd.wcnt_inc) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (i_cmd.init_wr) begin
                r_free_count <= r_n;
            end else if (i_cmd.alloc_take) begin
                r_free_count <= r_free_count - 1'b1;
            end else if (i_cmd.free_clr) begin
                r_free_count <= r_free_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_offset <= i_free_offset;
            r_size   <= eff_size;
        end
        if (i_cmd.alloc_take) begin
            r_pos <= PW'({r_wcnt, low_zero});
        end else if (i_cmd.rd_free) begin
            r_pos <= PW'(quotient);
        end
        if (i_cmd.mul) begin
            r_soff <= prod[OFS_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status   <= i_cmd.status;
            r_index    <= i_cmd.use_idx ? IDX_W'(r_pos) : '0;
            r_slot_off <= i_cmd.use_off ? r_soff : '0;
            r_fslots   <= CNT_W'(r_free_count);
        end
    end

    assign o_stat.wcnt_last = (r_wcnt == WCW'(Words - 1));
    assign o_stat.scan_more = (first_bit < n_ext);
    assign o_stat.word_full = (r_rdata == '1);
    assign o_stat.div_done  = div_done;
    assign o_stat.out_range = (quotient >= OFS_W'(r_n));
    assign o_stat.bit_used  = r_rdata[r_pos[WB_LOG-1:0]];
    assign o_stat.out_free  = out_free;

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_index;
    assign o_slot_offset = r_slot_off;
    assign o_free_slots  = r_fslots;

endmodule

// ===== hw/rtl/slab_bitmap_slot_allocator.sv =====
// Slab slot allocator for one pool of fixed-size objects, tracked in a used-slot
// bitmap of 64-bit words held in a small memory. Each transfer on the input
// channel carries one command and yields exactly one result transfer. Init
// marks the first object_count slots free and every other slot used, one
// memory word per cycle. Allocate reads the words from the lowest up, each
// with a memory read and then the lowest-zero search, until it finds a free
// slot or passes the configured count (pool full). Free divides the byte offset
// by the object size in a divider that yields one quotient bit per cycle; that
// divider sets the worst-case rate. One command is in flight at a time, but
// the next one is taken while the previous result still waits in the output
// register. After reset the block runs a clearing pass that writes the reset
// bitmap (slots 0 to 7 free) and holds stall high meanwhile; configuration
// writes are taken at any time and apply from the next command.

`include "slab_bitmap_slot_allocator_assert.svh"

module slab_bitmap_slot_allocator
    import sbsa_pkg::*;
#(
    parameter int MaxSlots = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command channel.
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [OFS_W-1:0]  i_free_offset,
    // Result channel.
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_slot_index,
    output logic [OFS_W-1:0]  o_slot_offset,
    output logic [CNT_W-1:0]  o_free_slots,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller sequences each command; the datapath holds the bitmap,
    // the free count, the divider, the offset multiplier and the output register.
    sbsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .o_cmd     (dp_cmd),
        .i_stat    (dp_stat)
    );

    sbsa_dpath #(
        .MaxSlots (MaxSlots)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_free_offset (i_free_offset),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_slot_offset (o_slot_offset),
        .o_free_slots  (o_free_slots)
    );

    // A result is only loaded when the output register is empty or draining.
    `SBSA_ASSERT_IMP(a_finish_room, dp_cmd.finish, dp_stat.out_free)
    // Only one kind of bitmap write happens in a cycle.
    `SBSA_ASSERT_IMP(a_wr_excl, 1'b1, $onehot0({dp_cmd.init_wr, dp_cmd.alloc_take, dp_cmd.free_clr}))
    // An allocation only takes a bit from a word that has a free slot.
    `SBSA_ASSERT_IMP(a_take_free, dp_cmd.alloc_take, !dp_stat.word_full)
    // Once a command is accepted the block is busy in the next cycle.
    `SBSA_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall)

endmodule

// ===== tb/slab_bitmap_slot_allocator_checker.sv =====
`timescale 1ns / 100ps

module slab_bitmap_slot_allocator_checker
    import sbsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  logic              i_cmd_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [OFS_W-1:0]  i_free_offset,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [STAT_W-1:0] i_status,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic [OFS_W-1:0]  i_slot_offset,
    input  logic [CNT_W-1:0]  i_free_slots,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_full_hits,
    output int                o_range_hits,
    output int                o_double_hits
);

    localparam int SLOTS = DEF_MAX_SLOTS;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot_index;
        logic [OFS_W-1:0]  slot_offset;
        logic [CNT_W-1:0]  free_slots;
    } t_slot_result;

    t_slot_result      expected_results[$];
    logic [SLOTS-1:0]  used_map;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  object_count;
    logic [SIZE_W-1:0] object_size;

    int error_count  = 0;
    int result_count = 0;
    int full_count   = 0;
    int range_count  = 0;
    int double_count = 0;
    int queue_depth  = 0;

    assign o_errors      = error_count;
    assign o_pending     = queue_depth;
    assign o_results     = result_count;
    assign o_full_hits   = full_count;
    assign o_range_hits  = range_count;
    assign o_double_hits = double_count;

    function automatic int unsigned pool_slots();
        return (object_count > SLOTS) ? SLOTS : int'(object_count);
    endfunction

    task automatic fill_pool(input int unsigned n);
        for (int s = 0; s < SLOTS; s++) begin
            used_map[s] = (s >= n);
        end
        free_count = CNT_W'(n);
    endtask

    task automatic predict_slot_result(input logic [CMD_W-1:0] cmd,
                                       input logic [OFS_W-1:0] ofs,
                                       output t_slot_result r);
        int unsigned n;
        int unsigned sz;
        int unsigned pos;
        int unsigned span;
        bit found;
        n = pool_slots();
        sz = (object_size == 0) ? 1 : int'(object_size);
        r = '0;
        case (cmd)
            CMD_INIT: begin
                fill_pool(n);
            end
            CMD_ALLOC: begin
                // The scan only covers whole words up to the configured count.
                span = ((n + WORD_BITS - 1) / WORD_BITS) * WORD_BITS;
                found = 1'b0;
                for (pos = 0; pos < span && !found; pos++) begin
                    if (!used_map[pos]) begin
                        used_map[pos] = 1'b1;
                        free_count = free_count - 1'b1;
                        r.slot_index = IDX_W'(pos);
                        r.slot_offset = OFS_W'(pos * sz);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_FULL;
                end
            end
            CMD_FREE: begin
                pos = int'(ofs) / sz;
                if (pos >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.slot_index = IDX_W'(pos);
                    if (!used_map[pos]) begin
                        r.status = ST_DOUBLE;
                    end else begin
                        used_map[pos] = 1'b0;
                        free_count = free_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.free_slots = free_count;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_slot_result want;
        t_slot_result seen;
        if (!i_rst_n) begin
            object_count = CNT_W'(RST_COUNT);
            object_size = SIZE_W'(RST_SIZE);
            fill_pool(RST_COUNT);
            expected_results.delete();
        end else begin
            // A result leaving at this edge belongs to an earlier command, so it is
            // matched before the command taken at the same edge is predicted.
            if (i_res_valid && !i_res_stall) begin
                result_count++;
                seen = '{i_status, i_slot_index, i_slot_offset, i_free_slots};
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                             $time, seen.status, seen.slot_index);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, seen.status);
                    compare_field("slot_index", want.slot_index, seen.slot_index);
                    compare_field("slot_offset", want.slot_offset, seen.slot_offset);
                    compare_field("free_slots", want.free_slots, seen.free_slots);
                    case (want.status)
                        ST_FULL:   full_count++;
                        ST_RANGE:  range_count++;
                        ST_DOUBLE: double_count++;
                        default: begin
                        end
                    endcase
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OBJ_COUNT) begin
                    object_count = i_cfg_data[CNT_W-1:0];
                end else begin
                    object_size = i_cfg_data;
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                predict_slot_result(i_command, i_free_offset, want);
                expected_results.push_back(want);
            end
        end
        queue_depth = expected_results.size();
    end

endmodule

// ===== tb/slab_bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 100ps

// Top of the allocator testbench. It produces the command stream, the result-side
// stall pattern and the register writes, while a checker instance beside the block
// predicts every result and compares it. The verdict is taken from the checker's
// error count and from any prediction still waiting at the end.
module slab_bitmap_slot_allocator_tb;
    import sbsa_pkg::*;

    // The fourth command code is unused by the block; it must leave the pool alone.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Directed items come first; the random part runs until this many are sent.
    localparam int ITEM_TARGET = 1825;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [CMD_W-1:0]  i_command     = '0;
    logic [OFS_W-1:0]  i_free_offset = '0;
    logic              i_stall       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_index   = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data    = '0;

    wire               o_stall;
    wire               o_valid;
    wire [STAT_W-1:0]  o_status;
    wire [IDX_W-1:0]   o_slot_index;
    wire [OFS_W-1:0]   o_slot_offset;
    wire [CNT_W-1:0]   o_free_slots;

    int errors;
    int pending;
    int results;
    int full_hits;
    int range_hits;
    int double_hits;

    // Count of accepted command transfers; both traffic generators key off it.
    int items_sent = 0;
    int settings_used = 0;

    always #5 i_clk = ~i_clk;

    slab_bitmap_slot_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_free_offset (i_free_offset),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_slot_offset (o_slot_offset),
        .o_free_slots  (o_free_slots),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    slab_bitmap_slot_allocator_checker result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_stall   (o_stall),
        .i_command     (i_command),
        .i_free_offset (i_free_offset),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_status      (o_status),
        .i_slot_index  (o_slot_index),
        .i_slot_offset (o_slot_offset),
        .i_free_slots  (o_free_slots),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results),
        .o_full_hits   (full_hits),
        .o_range_hits  (range_hits),
        .o_double_hits (double_hits)
    );

    // Both sides stop idling for a stretch in the middle of the run, so the block
    // also sees back-to-back traffic.
    function automatic bit quiet_stretch();
        return items_sent >= 700 && items_sent < 1000;
    endfunction

    // Offers one command and returns at the falling edge after its transfer. While
    // the sender idles, the payload wanders so that stale data is never trusted.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [OFS_W-1:0] ofs);
        while (!quiet_stretch() && $urandom_range(99, 0) < 16) begin
            i_valid <= 1'b0;
            i_command <= CMD_W'($urandom);
            i_free_offset <= OFS_W'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_free_offset <= ofs;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // Lets every outstanding result come back so the block is idle. Each command
    // yields exactly one result, so a short margin after the last one is enough.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stall, plus two long hold-offs while the sender keeps
    // offering commands, which backs the block up until it stalls its input.
    initial begin : result_sink
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < 2 && items_sent >= 300 + 1000 * holds_done) begin
                hold_left = 400;
                holds_done++;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= !quiet_stretch() && ($urandom_range(99, 0) < 16);
            end
        end
    end

    initial begin : stimulus
        int unsigned count;
        int unsigned size;
        int unsigned pool_n;
        int unsigned pool_sz;
        int unsigned slot;
        int unsigned addr;
        int ops;
        int k;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, starting from the reset pool of eight 64-byte slots.
        send_cmd(CMD_ALLOC, 22'd0);
        send_cmd(CMD_ALLOC, 22'd0);
        send_cmd(CMD_FREE, 22'd64);
        send_cmd(CMD_FREE, 22'd64);          // the same slot again is a double free
        send_cmd(CMD_FREE, 22'd63);          // rounds down into slot zero
        send_cmd(CMD_FREE, 22'd512);         // first offset past the pool
        send_cmd(CMD_FREE, 22'h3FFFFF);
        send_cmd(CMD_SPARE, 22'h2AAAAA);
        send_cmd(CMD_INIT, 22'h155555);

        // An empty pool: nothing to hand out and nothing that can be freed.
        write_reg(CFG_OBJ_COUNT, 17'd0);
        send_cmd(CMD_ALLOC, 22'd0);
        send_cmd(CMD_FREE, 22'd0);
        send_cmd(CMD_INIT, 22'd0);

        // A count above the slot limit is clamped. The empty bitmap is kept, one
        // high slot is released, and a huge object size makes its offset wrap.
        write_reg(CFG_OBJ_COUNT, 17'd1023);
        write_reg(CFG_OBJ_SIZE, 17'd1);
        send_cmd(CMD_FREE, 22'd500);
        send_cmd(CMD_FREE, 22'd500);
        write_reg(CFG_OBJ_SIZE, 17'h1FFFF);
        send_cmd(CMD_ALLOC, 22'd0);
        send_cmd(CMD_ALLOC, 22'd0);

        // Size zero behaves as one byte per slot.
        write_reg(CFG_OBJ_SIZE, 17'd0);
        send_cmd(CMD_FREE, 22'd3);
        send_cmd(CMD_ALLOC, 22'd0);

        // A single slot of the largest nominal size.
        write_reg(CFG_OBJ_COUNT, 17'd1);
        write_reg(CFG_OBJ_SIZE, 17'd65536);
        send_cmd(CMD_INIT, 22'd0);
        send_cmd(CMD_ALLOC, 22'd0);
        send_cmd(CMD_ALLOC, 22'd0);
        send_cmd(CMD_FREE, 22'd65536);
        send_cmd(CMD_FREE, 22'd65535);

        // Random part, in phases of one pool setting each. Small pools dominate so
        // that full pools and double frees come up often.
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(9, 0))
                0: count = 0;
                1: count = 1;
                2: count = $urandom_range(1023, 513);
                3: count = 512;
                8: count = $urandom_range(128, 17);
                9: count = $urandom_range(511, 129);
                default: count = $urandom_range(16, 1);
            endcase
            case ($urandom_range(7, 0))
                0: size = 0;
                1: size = 1;
                2: size = 65536;
                3: size = 17'h1FFFF;
                4: size = $urandom_range(64, 1);
                5: size = $urandom_range(4096, 65);
                6: size = $urandom & 17'h1FFFF;
                default: size = 64;
            endcase
            // The bits above the count field are junk and must be dropped.
            write_reg(CFG_OBJ_COUNT, {7'($urandom), 10'(count)});
            write_reg(CFG_OBJ_SIZE, 17'(size));
            settings_used++;
            pool_n = (count > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : count;
            pool_sz = (size == 0) ? 1 : size;

            // Now and then the settings change without an init, so the old bitmap
            // is scanned under the new count.
            if ($urandom_range(5, 0) != 0) begin
                send_cmd(CMD_INIT, OFS_W'($urandom));
            end
            if (pool_n <= 80 && $urandom_range(99, 0) < 40) begin
                repeat (pool_n + 2) send_cmd(CMD_ALLOC, OFS_W'($urandom));
            end

            ops = $urandom_range(80, 20);
            for (k = 0; k < ops; k++) begin
                case ($urandom_range(99, 0)) inside
                    [0:44]: begin
                        send_cmd(CMD_ALLOC, OFS_W'($urandom));
                    end
                    [45:84]: begin
                        // Free an address somewhere inside a slot of the pool.
                        slot = (pool_n == 0) ? 0 : $urandom_range(pool_n - 1, 0);
                        addr = slot * pool_sz + $urandom_range(pool_sz - 1, 0);
                        if (addr > 32'h3FFFFF) begin
                            addr = $urandom;
                        end
                        send_cmd(CMD_FREE, OFS_W'(addr));
                    end
                    [85:91]: begin
                        send_cmd(CMD_FREE, OFS_W'($urandom));
                    end
                    [92:95]: begin
                        send_cmd(CMD_INIT, OFS_W'($urandom));
                    end
                    default: begin
                        send_cmd(CMD_SPARE, OFS_W'($urandom));
                    end
                endcase
            end
        end

        // Wind down: wait for the last results, bounded, then a short tail.
        i_valid <= 1'b0;
        for (k = 0; k < 20000 && pending != 0; k++) begin
            @(negedge i_clk);
        end
        repeat (40) @(negedge i_clk);

        $display("Run covered %0d commands across %0d pool settings; %0d results checked.",
                 items_sent, settings_used, results);
        $display("Error paths seen: %0d pool full, %0d out of range, %0d double free.",
                 full_hits, range_hits, double_hits);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial begin : watchdog
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sbsa_pkg.sv
hw/rtl/sbsa_div.sv
hw/rtl/sbsa_ctrl.sv
hw/rtl/sbsa_dpath.sv
hw/rtl/slab_bitmap_slot_allocator.sv
tb/slab_bitmap_slot_allocator_checker.sv
tb/slab_bitmap_slot_allocator_tb.sv
